// ===== hw/rtl/uer_pkg.sv =====
`default_nettype none
package uer_pkg;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic        trigger;
    logic        done_res;
    logic [15:0] distance;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  ticks_per_cm;
    logic [15:0] no_echo_value;
    logic [7:0]  settle_ticks;
    logic [7:0]  pulse_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SETTLE    = 3'd1,
    PH_PULSE     = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_HIGH      = 3'd4
  } phase_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPC      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NO_ECHO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 3'd4;

  localparam logic [15:0] TIMEOUT_RST = 16'd50000;
  localparam logic [7:0]  TPC_RST     = 8'd58;
  localparam logic [15:0] NO_ECHO_RST = 16'd51;
  localparam logic [7:0]  SETTLE_RST  = 8'd2;
  localparam logic [7:0]  PULSE_RST   = 8'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/uer_core.sv =====
`default_nettype none
module uer_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire uer_pkg::tick_t  tick,
  input  wire uer_pkg::cfg_t   cfg,
  output uer_pkg::result_t     result
);
  import uer_pkg::*;

  phase_t      phase, phase_next;
  logic [16:0] phase_ticks, phase_ticks_next;
  logic [15:0] cm_count, cm_count_next;
  logic [7:0]  prescale_count, prescale_count_next;

  logic [16:0] ptk_inc;
  logic [16:0] hb_ptk, hc_ptk;
  logic [15:0] hb_cm, hc_cm;
  logic [7:0]  hb_psc, hc_psc_inc, hc_psc;
  logic        bump;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      phase_ticks    <= '0;
      cm_count       <= '0;
      prescale_count <= '0;
    end else if (step) begin
      phase          <= phase_next;
      phase_ticks    <= phase_ticks_next;
      cm_count       <= cm_count_next;
      prescale_count <= prescale_count_next;
    end
  end

  // one echo-high tick; a fresh rise starts from cleared counters
  always_comb begin
    hb_ptk     = (phase == PH_HIGH) ? phase_ticks : '0;
    hb_cm      = (phase == PH_HIGH) ? cm_count : '0;
    hb_psc     = (phase == PH_HIGH) ? prescale_count : '0;
    hc_ptk     = (hb_ptk != '1) ? hb_ptk + 17'd1 : hb_ptk;
    hc_psc_inc = hb_psc + 8'd1;
    bump       = (hc_psc_inc >= cfg.ticks_per_cm);
    hc_psc     = bump ? 8'd0 : hc_psc_inc;
    hc_cm      = (bump && hb_cm != '1) ? hb_cm + 16'd1 : hb_cm;
  end

  always_comb begin
    phase_next          = phase;
    phase_ticks_next    = phase_ticks;
    cm_count_next       = cm_count;
    prescale_count_next = prescale_count;
    result              = '0;
    ptk_inc             = phase_ticks + 17'd1;
    case (phase)
      PH_SETTLE: begin
        phase_ticks_next = ptk_inc;
        if (ptk_inc >= {9'd0, cfg.settle_ticks}) begin
          phase_next       = PH_PULSE;
          phase_ticks_next = '0;
        end
      end
      PH_PULSE: begin
        result.trigger   = 1'b1;
        phase_ticks_next = ptk_inc;
        if (ptk_inc >= {9'd0, cfg.pulse_ticks}) begin
          phase_next       = PH_WAIT_RISE;
          phase_ticks_next = '0;
        end
      end
      PH_WAIT_RISE, PH_HIGH: begin
        if (tick.echo) begin
          phase_next          = PH_HIGH;
          phase_ticks_next    = hc_ptk;
          cm_count_next       = hc_cm;
          prescale_count_next = hc_psc;
          if (hc_ptk > {1'b0, cfg.timeout_ticks}) begin
            result.done_res = 1'b1;
            result.distance = hc_cm;
            result.status   = ST_TOO_LONG;
            phase_next      = PH_IDLE;
          end
        end else if (phase == PH_HIGH) begin
          result.done_res = 1'b1;
          result.distance = cm_count;
          result.status   = ST_OK;
          phase_next      = PH_IDLE;
        end else begin
          phase_ticks_next = ptk_inc;
          if (ptk_inc > {1'b0, cfg.timeout_ticks}) begin
            result.done_res = 1'b1;
            result.distance = cfg.no_echo_value;
            result.status   = ST_NO_ECHO;
            phase_next      = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (tick.start_req) begin
          phase_ticks_next = '0;
          phase_next       = (cfg.settle_ticks == 8'd0) ? PH_PULSE : PH_SETTLE;
        end
      end
    endcase
  end

  no_trig_on_done: assert property (@(posedge clk) disable iff (rst)
    result.done_res |-> !result.trigger)
    else $error("trigger and done together");

  rise_from_wait: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_HIGH |=> phase == PH_HIGH || phase == PH_IDLE)
    else $error("bad exit from echo high phase");

  settle_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SETTLE || phase == PH_PULSE |-> phase_ticks[16:8] == '0)
    else $error("trigger phase count out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Each accepted tick updates the phase and counter registers once, and its
// result is registered in the result register, or in the skid while the
// result register is held. Throughput: one tick per cycle while the skid is
// empty (tick_stall low). A two-entry output buffer (result register plus
// skid) takes one more tick while the result side stalls.
// Reset: phase idle, counters zero, registers at their defaults, no result.
`default_nettype none
module ultrasonic_echo_ranger (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              tick_valid,
  output logic                                   tick_stall,
  input  wire uer_pkg::tick_t                    tick,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output uer_pkg::result_t                       res,
  input  wire logic                              cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import uer_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t skid;
  logic    skid_valid;
  logic    accept;
  logic    take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RST;
      cfg.ticks_per_cm  <= TPC_RST;
      cfg.no_echo_value <= NO_ECHO_RST;
      cfg.settle_ticks  <= SETTLE_RST;
      cfg.pulse_ticks   <= PULSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        REG_TPC:     cfg.ticks_per_cm  <= cfg_data[7:0];
        REG_NO_ECHO: cfg.no_echo_value <= cfg_data;
        REG_SETTLE:  cfg.settle_ticks  <= cfg_data[7:0];
        REG_PULSE:   cfg.pulse_ticks   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign tick_stall = skid_valid;
  assign accept     = tick_valid && !skid_valid;
  assign take       = res_valid && !res_stall;

  uer_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .tick   (tick),
    .cfg    (cfg),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end else if (accept) begin
        res <= step_res;
      end else begin
        res_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!res_valid) begin
        res       <= step_res;
        res_valid <= 1'b1;
      end else begin
        skid       <= step_res;
        skid_valid <= 1'b1;
      end
    end
  end

  skid_needs_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds an item ahead of the result register");

  idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.done_res |-> res.distance == '0 && res.status == ST_OK)
    else $error("result fields set without done");

  status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> res.status != 2'd3)
    else $error("undefined status code");

  empty_after_rst: assert property (@(posedge clk)
    rst |=> !res_valid && !skid_valid)
    else $error("buffer not empty after reset");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

import uer_pkg::*;

class echo_range_tracker;
  cfg_t        regs;
  phase_t      phase;
  logic [16:0] phase_ticks;
  logic [15:0] cm_count;
  logic [7:0]  prescale_count;
  result_t     expected_results[$];
  int          failures;

  function void clear();
    regs.timeout_ticks = TIMEOUT_RST;
    regs.ticks_per_cm  = TPC_RST;
    regs.no_echo_value = NO_ECHO_RST;
    regs.settle_ticks  = SETTLE_RST;
    regs.pulse_ticks   = PULSE_RST;
    phase              = PH_IDLE;
    phase_ticks        = '0;
    cm_count           = '0;
    prescale_count     = '0;
    failures           = 0;
    expected_results.delete();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TIMEOUT: regs.timeout_ticks = data;
      REG_TPC:     regs.ticks_per_cm  = data[7:0];
      REG_NO_ECHO: regs.no_echo_value = data;
      REG_SETTLE:  regs.settle_ticks  = data[7:0];
      REG_PULSE:   regs.pulse_ticks   = data[7:0];
      default: ;
    endcase
  endfunction

  function void bump_echo_count();
    if (phase_ticks < 17'h1FFFF)
      phase_ticks = phase_ticks + 17'd1;
    prescale_count = prescale_count + 8'd1;
    if (prescale_count >= regs.ticks_per_cm) begin
      prescale_count = '0;
      if (cm_count != 16'hFFFF)
        cm_count = cm_count + 16'd1;
    end
  endfunction

  function result_t predict_tick(tick_t t);
    result_t r;
    r = '0;
    case (phase)
      PH_SETTLE: begin
        phase_ticks = phase_ticks + 17'd1;
        if (phase_ticks >= regs.settle_ticks) begin
          phase       = PH_PULSE;
          phase_ticks = '0;
        end
      end
      PH_PULSE: begin
        r.trigger   = 1'b1;
        phase_ticks = phase_ticks + 17'd1;
        if (phase_ticks >= regs.pulse_ticks) begin
          phase       = PH_WAIT_RISE;
          phase_ticks = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (t.echo) begin
          phase          = PH_HIGH;
          phase_ticks    = '0;
          cm_count       = '0;
          prescale_count = '0;
          bump_echo_count();
          if (phase_ticks > regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.distance = cm_count;
            r.status   = ST_TOO_LONG;
            phase      = PH_IDLE;
          end
        end else begin
          phase_ticks = phase_ticks + 17'd1;
          if (phase_ticks > regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.distance = regs.no_echo_value;
            r.status   = ST_NO_ECHO;
            phase      = PH_IDLE;
          end
        end
      end
      PH_HIGH: begin
        if (t.echo) begin
          bump_echo_count();
          if (phase_ticks > regs.timeout_ticks) begin
            r.done_res = 1'b1;
            r.distance = cm_count;
            r.status   = ST_TOO_LONG;
            phase      = PH_IDLE;
          end
        end else begin
          r.done_res = 1'b1;
          r.distance = cm_count;
          r.status   = ST_OK;
          phase      = PH_IDLE;
        end
      end
      default: begin
        phase = PH_IDLE;
        if (t.start_req) begin
          phase_ticks = '0;
          phase       = (regs.settle_ticks == 8'd0) ? PH_PULSE : PH_SETTLE;
        end
      end
    endcase
    return r;
  endfunction

  function void note_tick(tick_t t);
    expected_results.push_back(predict_tick(t));
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: trigger %0b done %0b distance %0d status %0d",
                 got.trigger, got.done_res, got.distance, got.status);
      return;
    end
    want = expected_results.pop_front();
    if (got.trigger !== want.trigger || got.done_res !== want.done_res ||
        got.distance !== want.distance || got.status !== want.status) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: trigger %0b/%0b done %0b/%0b distance %0d/%0d status %0d/%0d",
                 want.trigger, got.trigger, want.done_res, got.done_res,
                 want.distance, got.distance, want.status, got.status);
    end
  endfunction
endclass

module testbench;
  logic                  clk;
  logic                  rst;
  logic                  tick_valid;
  logic                  tick_stall;
  tick_t                 tick;
  logic                  res_valid;
  logic                  res_stall;
  result_t               res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  echo_range_tracker tracker;
  cfg_t              cur_cfg;
  int                burst_left;
  int                ticks_sent;

  ultrasonic_echo_ranger dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // inputs are noted before results are checked within the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_valid && !tick_stall)
        tracker.note_tick(tick);
      if (res_valid && !res_stall)
        tracker.check_result(res);
    end
  end

  initial begin
    int stall_pct;
    int mode_left;
    res_stall = 1'b0;
    stall_pct = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_pct = $urandom_range(0, 3) * 30;
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_tick(input logic start_req, input logic echo);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    tick_valid <= 1'b1;
    tick       <= tick_t'({start_req, echo});
    do @(posedge clk); while (tick_stall);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input int n, input logic echo, input int start_pct);
    repeat (n) send_tick($urandom_range(0, 99) < start_pct, echo);
  endtask

  task automatic noise(input int n);
    repeat (n) send_tick($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (tracker.expected_results.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0] bad_idx;
    drain();
    cur_cfg = c;
    put_reg(REG_TIMEOUT, c.timeout_ticks);
    put_reg(REG_TPC, {8'($urandom), c.ticks_per_cm});
    put_reg(REG_NO_ECHO, c.no_echo_value);
    put_reg(REG_SETTLE, {8'($urandom), c.settle_ticks});
    put_reg(REG_PULSE, {8'($urandom), c.pulse_ticks});
    bad_idx = CFG_IDX_W'(int'(REG_PULSE) + 1 + int'($urandom_range(0, 2)));
    put_reg(bad_idx, 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    case ($urandom_range(0, 5))
      0:       c.timeout_ticks = 16'd0;
      1:       c.timeout_ticks = 16'd1;
      2:       c.timeout_ticks = 16'hFFFF;
      default: c.timeout_ticks = 16'($urandom_range(2, 30));
    endcase
    case ($urandom_range(0, 5))
      0:       c.ticks_per_cm = 8'd0;
      1:       c.ticks_per_cm = 8'd1;
      2:       c.ticks_per_cm = 8'hFF;
      default: c.ticks_per_cm = 8'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       c.no_echo_value = 16'd0;
      1:       c.no_echo_value = 16'hFFFF;
      default: c.no_echo_value = 16'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0, 1, 2, 3: c.settle_ticks = 8'd0;
      4:          c.settle_ticks = 8'hFF;
      default:    c.settle_ticks = 8'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 11))
      0, 1, 2: c.pulse_ticks = 8'd0;
      3:       c.pulse_ticks = 8'hFF;
      4, 5:    c.pulse_ticks = 8'd1;
      default: c.pulse_ticks = 8'($urandom_range(2, 4));
    endcase
    return c;
  endfunction

  // one trigger sequence with a random wait and echo length, or with no echo until the timeout
  task automatic measure();
    int to;
    int pre;
    int wait_len;
    int high_len;
    int lim;
    to  = int'(cur_cfg.timeout_ticks);
    pre = int'(cur_cfg.settle_ticks) +
          ((cur_cfg.pulse_ticks == 8'd0) ? 1 : int'(cur_cfg.pulse_ticks));
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (pre) send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0: wait_len = 0;
      1: begin
        if (to < 200) begin
          send_run(to + 1, 1'b0, 25);
          return;
        end
        wait_len = $urandom_range(0, 40);
      end
      default: wait_len = $urandom_range(0, (to < 40) ? to : 40);
    endcase
    send_run(wait_len, 1'b0, 25);
    lim      = (to < 60) ? to + 2 : 60;
    high_len = $urandom_range(1, lim);
    send_run(high_len, 1'b1, 25);
    if (high_len <= to)
      send_tick($urandom_range(0, 3) == 0, 1'b0);
  endtask

  initial begin
    cfg_t c;
    int   mark;
    tracker    = new;
    tracker.clear();
    rst        = 1'b1;
    tick_valid = 1'b0;
    tick       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    ticks_sent = 0;
    cur_cfg    = '{TIMEOUT_RST, TPC_RST, NO_ECHO_RST, SETTLE_RST, PULSE_RST};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values, start requests while busy
    send_tick(1'b1, 1'b0);
    send_run(12, 1'b1, 30);
    send_run(2, 1'b0, 0);
    send_run(3, 1'b1, 100);
    send_tick(1'b0, 1'b0);

    // saturating count, zero settle, zero pulse, zero ticks per cm
    c = '{16'hFFFF, 8'd0, 16'hFFFF, 8'd0, 8'd0};
    program_regs(c);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_run(65536, 1'b1, 10);
    noise(3);

    // zero timeout, longest trigger sequence
    c = '{16'd0, 8'hFF, 16'd0, 8'hFF, 8'hFF};
    program_regs(c);
    measure();
    measure();

    mark = ticks_sent;
    while (ticks_sent - mark < 1200) begin
      program_regs(random_cfg());
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          noise($urandom_range(1, 12));
        end else begin
          measure();
          noise($urandom_range(0, 3));
        end
      end
    end

    drain();
    if (tracker.expected_results.size() != 0)
      tracker.failures++;
    if (tracker.failures == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("testbench failed");
    $finish;
  end
endmodule
